>>> rtl/wlp_pkg.sv
// Shared types and constants for the weighted line partition unit.
// Holds the command and status structs that join the controller and datapath.
// Depends on nothing else.
package wlp_pkg;

	// Fixed field widths of the stream items and the register.
	localparam int WEIGHT_W = 16;
	localparam int COST_OUT_W = 40;
	localparam int NG_W = 4;

	// Which address the shared memory read port uses.
	typedef enum logic [1:0] {
		RD_MID  = 2'd0,
		RD_SPLIT = 2'd1,
		RD_LAST = 2'd2
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    check;
		logic    sweep;
		logic    push_root;
		logic    pop;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    mid_load;
		logic    k_diff;
		logic    k_mul;
		logic    k_cmp;
		logic    span_end;
		logic    push_left;
		logic    layer_next;
		logic    res_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic infeasible;
		logic sweep_last;
		logic stack_empty;
		logic k_none;
		logic k_last;
		logic layer_last;
		logic out_busy;
	} sts_t;

endpackage

>>> rtl/wlp_ctrl.sv
// Controller state machine for the weighted line partition unit.
// Sequences loading, layer sweeps, stack-driven span solving and the result.
// Depends on wlp_pkg.
module wlp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  wlp_pkg::sts_t sts,
	output wlp_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_CHECK,
		S_SWEEP,
		S_ROOT,
		S_POP,
		S_MRD,
		S_MLD,
		S_KRD,
		S_KDIF,
		S_KMUL,
		S_KCMP,
		S_SEND,
		S_PUSHL,
		S_LEND,
		S_FRD,
		S_OUT
	} state_t;

	state_t state_q;

	// Next-state logic and state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid && in_last) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.infeasible) state_q <= S_OUT;
					else state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (sts.sweep_last) state_q <= S_ROOT;
				end
				S_ROOT: state_q <= S_POP;
				S_POP: begin
					if (sts.stack_empty) state_q <= S_LEND;
					else state_q <= S_MRD;
				end
				S_MRD: state_q <= S_MLD;
				S_MLD: begin
					if (sts.k_none) state_q <= S_SEND;
					else state_q <= S_KRD;
				end
				S_KRD: state_q <= S_KDIF;
				S_KDIF: state_q <= S_KMUL;
				S_KMUL: state_q <= S_KCMP;
				S_KCMP: begin
					if (sts.k_last) state_q <= S_SEND;
					else state_q <= S_KRD;
				end
				S_SEND: state_q <= S_PUSHL;
				S_PUSHL: state_q <= S_POP;
				S_LEND: begin
					if (sts.layer_last) state_q <= S_FRD;
					else state_q <= S_SWEEP;
				end
				S_FRD: state_q <= S_OUT;
				S_OUT: begin
					if (!sts.out_busy) state_q <= S_LOAD;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		cmd.rd_sel = wlp_pkg::RD_MID;
		in_ready = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CHECK: cmd.check = 1'b1;
			S_SWEEP: cmd.sweep = 1'b1;
			S_ROOT:  cmd.push_root = 1'b1;
			S_POP:   cmd.pop = !sts.stack_empty;
			S_MRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = wlp_pkg::RD_MID;
			end
			S_MLD: cmd.mid_load = 1'b1;
			S_KRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = wlp_pkg::RD_SPLIT;
			end
			S_KDIF: cmd.k_diff = 1'b1;
			S_KMUL: cmd.k_mul = 1'b1;
			S_KCMP: cmd.k_cmp = 1'b1;
			S_SEND: cmd.span_end = 1'b1;
			S_PUSHL: cmd.push_left = 1'b1;
			S_LEND: cmd.layer_next = 1'b1;
			S_FRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = wlp_pkg::RD_LAST;
			end
			S_OUT: cmd.res_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/wlp_dp.sv
// Datapath of the weighted line partition unit: prefix memories, the two
// cost layer memories, the span stack, the cost arithmetic and the output
// register. Depends on wlp_pkg.
module wlp_dp #(
	parameter int MAX_ITEMS  = 4096,
	parameter int MAX_GROUPS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wlp_pkg::cmd_t                   cmd,
	output wlp_pkg::sts_t                   sts,
	input  logic [wlp_pkg::WEIGHT_W-1:0]    in_weight,
	input  logic                            in_last,
	input  logic [wlp_pkg::NG_W-1:0]        num_groups,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wlp_pkg::COST_OUT_W-1:0]  out_cost,
	output logic                            out_feasible
);

	localparam int IDX_W = $clog2(MAX_ITEMS + 1);
	localparam longint WMAX = (longint'(1) << wlp_pkg::WEIGHT_W) - 1;
	localparam int WS_W = $clog2(WMAX * longint'(MAX_ITEMS) + 1);
	localparam int WP_W =
		$clog2(WMAX * (longint'(MAX_ITEMS) * longint'(MAX_ITEMS + 1) / 2) + 1);
	localparam int COST_W = WP_W + 1;
	localparam int LAYER_W = $clog2(MAX_GROUPS + 1);
	localparam int STK_D = IDX_W + 2;
	localparam int SP_W = $clog2(STK_D + 1);
	localparam int SPI_W = $clog2(STK_D);
	localparam int DEPTH = MAX_ITEMS + 1;
	localparam logic [COST_W-1:0] COST_INF = '1;

	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [IDX_W-1:0] klo;
		logic [IDX_W-1:0] khi;
	} span_t;

	// Prefix and cost memories.
	logic [WS_W-1:0]   ws_mem [DEPTH];
	logic [WP_W-1:0]   wp_mem [DEPTH];
	logic [COST_W-1:0] ca_mem [DEPTH];
	logic [COST_W-1:0] cb_mem [DEPTH];

	logic [WS_W-1:0]   ws_rd_q;
	logic [WP_W-1:0]   wp_rd_q;
	logic [COST_W-1:0] ca_rd_q, cb_rd_q;
	logic              rd_zero_q;

	// Sequence and layer state.
	logic [IDX_W-1:0]   count_q, n_q, idx_q;
	logic [WS_W-1:0]    ws_acc_q;
	logic [WP_W-1:0]    wp_acc_q;
	logic [LAYER_W-1:0] layer_q;
	logic               sel_q, feas_q;

	// Span and split-point state.
	span_t              stk_q [STK_D];
	logic [SP_W-1:0]    sp_q;
	logic [IDX_W-1:0]   lo_q, hi_q, klo_q, khi_q, m_q, kend_q, k_q, best_q;
	logic [WS_W-1:0]    wsm_q, wsd_q;
	logic [WP_W-1:0]    wpm_q, wpd_q, prod_q;
	logic [COST_W-1:0]  curm_q, prev_q;

	// Output register.
	logic                           out_valid_q, out_feas_q;
	logic [wlp_pkg::COST_OUT_W-1:0] out_cost_q;

	// Combinational helpers.
	logic [IDX_W-1:0]   p_nx, n_nx, rd_addr, mid, kend;
	logic               sat;
	logic [WS_W-1:0]    ws_nx, ws_val;
	logic [WP_W-1:0]    wp_nx, wp_val, cost;
	logic [wlp_pkg::WEIGHT_W+IDX_W-1:0] wprod;
	logic [COST_W-1:0]  cur_rd, prev_rd;
	logic [COST_W:0]    cand;
	logic [LAYER_W-1:0] groups;
	logic [IDX_W:0]     lohi;
	span_t              top;
	logic               cur_we;
	logic [IDX_W-1:0]   cur_wa;
	logic [COST_W-1:0]  cur_wd;
	logic               push_r, push_l;

	// Loading: running prefix sums and the position of the next item.
	always_comb begin
		sat   = (int'(count_q) >= MAX_ITEMS);
		p_nx  = count_q + IDX_W'(1);
		n_nx  = sat ? count_q : p_nx;
		wprod = (wlp_pkg::WEIGHT_W + IDX_W)'(in_weight) * (wlp_pkg::WEIGHT_W + IDX_W)'(p_nx);
		ws_nx = ws_acc_q + WS_W'(in_weight);
		wp_nx = wp_acc_q + WP_W'(wprod);
	end

	// Group count clamped to the supported maximum.
	always_comb begin
		if (int'(num_groups) > MAX_GROUPS) groups = LAYER_W'(MAX_GROUPS);
		else groups = LAYER_W'(num_groups);
	end

	// Shared read address.
	always_comb begin
		unique case (cmd.rd_sel)
			wlp_pkg::RD_MID:   rd_addr = m_q;
			wlp_pkg::RD_SPLIT: rd_addr = k_q - IDX_W'(1);
			wlp_pkg::RD_LAST:  rd_addr = n_q;
			default:           rd_addr = m_q;
		endcase
	end

	// Entry zero of the prefix sums always reads as zero.
	always_comb begin
		ws_val  = rd_zero_q ? '0 : ws_rd_q;
		wp_val  = rd_zero_q ? '0 : wp_rd_q;
		cur_rd  = sel_q ? cb_rd_q : ca_rd_q;
		prev_rd = sel_q ? ca_rd_q : cb_rd_q;
	end

	// Prefix memories: written while loading, read during the search.
	always_ff @(posedge clk) begin
		if (cmd.load && !sat) begin
			ws_mem[p_nx] <= ws_nx;
			wp_mem[p_nx] <= wp_nx;
		end
		if (cmd.rd_en) begin
			ws_rd_q   <= ws_mem[rd_addr];
			wp_rd_q   <= wp_mem[rd_addr];
			rd_zero_q <= (rd_addr == '0);
		end
	end

	// Write port of the current cost layer: clearing sweep or span result.
	always_comb begin
		cur_we = cmd.sweep || (cmd.span_end && best_q != '0);
		cur_wa = cmd.sweep ? idx_q : m_q;
		cur_wd = cmd.sweep ? COST_INF : curm_q;
	end

	// Cost layer memories, swapped in role after each layer.
	always_ff @(posedge clk) begin
		if (cur_we && !sel_q) ca_mem[cur_wa] <= cur_wd;
		if (cmd.rd_en) ca_rd_q <= ca_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cur_we && sel_q) cb_mem[cur_wa] <= cur_wd;
		if (cmd.rd_en) cb_rd_q <= cb_mem[rd_addr];
	end

	// Span arithmetic: middle point and the last split point to try.
	always_comb begin
		top  = stk_q[SPI_W'(sp_q - SP_W'(1))];
		lohi = {1'b0, top.lo} + {1'b0, top.hi};
		mid  = lohi[IDX_W:1];
		kend = (top.khi < mid) ? top.khi : mid;
		cost = wpd_q - prod_q;
		cand = {2'b00, cost} + {1'b0, prev_q};
		push_r = (best_q != '0) && (m_q < hi_q) && (int'(sp_q) < STK_D);
		push_l = (best_q != '0) && (m_q > lo_q) && (int'(sp_q) < STK_D);
	end

	// Sequence control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ws_acc_q <= '0;
			wp_acc_q <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			layer_q  <= '0;
			sel_q    <= 1'b0;
			feas_q   <= 1'b0;
			sp_q     <= '0;
		end else begin
			if (cmd.load) begin
				if (in_last) begin
					count_q  <= '0;
					ws_acc_q <= '0;
					wp_acc_q <= '0;
					n_q      <= n_nx;
				end else if (!sat) begin
					count_q  <= p_nx;
					ws_acc_q <= ws_nx;
					wp_acc_q <= wp_nx;
				end
			end
			if (cmd.check) begin
				feas_q  <= !sts.infeasible;
				layer_q <= LAYER_W'(1);
				idx_q   <= '0;
				sp_q    <= '0;
			end
			if (cmd.sweep) idx_q <= idx_q + IDX_W'(1);
			if (cmd.layer_next) begin
				sel_q   <= !sel_q;
				layer_q <= layer_q + LAYER_W'(1);
				idx_q   <= '0;
			end
			// Stack pointer moves on push and pop.
			if (cmd.push_root) sp_q <= SP_W'(1);
			if (cmd.pop) sp_q <= sp_q - SP_W'(1);
			if (cmd.span_end && push_r) sp_q <= sp_q + SP_W'(1);
			if (cmd.push_left && push_l) sp_q <= sp_q + SP_W'(1);
		end
	end

	// Stack entries hold spans still to be solved.
	always_ff @(posedge clk) begin
		if (cmd.push_root) begin
			stk_q[0] <= '{lo: IDX_W'(layer_q), hi: n_q, klo: IDX_W'(layer_q), khi: n_q};
		end
		if (cmd.span_end && push_r) begin
			stk_q[SPI_W'(sp_q)] <= '{lo: m_q + IDX_W'(1), hi: hi_q, klo: best_q, khi: khi_q};
		end
		if (cmd.push_left && push_l) begin
			stk_q[SPI_W'(sp_q)] <= '{lo: lo_q, hi: m_q - IDX_W'(1), klo: klo_q, khi: best_q};
		end
	end

	// Span registers and the split-point search.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			lo_q   <= top.lo;
			hi_q   <= top.hi;
			klo_q  <= top.klo;
			khi_q  <= top.khi;
			m_q    <= mid;
			kend_q <= kend;
			k_q    <= top.klo;
			best_q <= '0;
		end
		if (cmd.mid_load) begin
			wsm_q  <= ws_val;
			wpm_q  <= wp_val;
			curm_q <= cur_rd;
		end
		if (cmd.k_diff) begin
			wsd_q <= wsm_q - ws_val;
			wpd_q <= wpm_q - wp_val;
			if (layer_q == LAYER_W'(1)) prev_q <= rd_zero_q ? '0 : COST_INF;
			else prev_q <= prev_rd;
		end
		if (cmd.k_mul) prod_q <= WP_W'((WS_W + IDX_W)'(wsd_q) * (WS_W + IDX_W)'(k_q));
		if (cmd.k_cmp) begin
			if ({1'b0, curm_q} > cand) begin
				curm_q <= COST_W'(cand);
				best_q <= k_q;
			end
			k_q <= k_q + IDX_W'(1);
		end
	end

	// Result register: holds one result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_feas_q <= feas_q;
			if (!feas_q) out_cost_q <= '0;
			else if (prev_rd == COST_INF) out_cost_q <= '1;
			else out_cost_q <= wlp_pkg::COST_OUT_W'(prev_rd);
		end
	end

	// Status to the controller.
	always_comb begin
		sts.infeasible  = (groups == '0) || (int'(n_q) < int'(groups));
		sts.sweep_last  = (idx_q == n_q);
		sts.stack_empty = (sp_q == '0);
		sts.k_none      = (k_q > kend_q);
		sts.k_last      = (k_q == kend_q);
		sts.layer_last  = (layer_q == groups);
		sts.out_busy    = out_valid_q;
	end

	assign out_valid    = out_valid_q;
	assign out_cost     = out_cost_q;
	assign out_feasible = out_feas_q;

endmodule

>>> rtl/weighted_line_partition_dp_unit.sv
// Weighted line partition unit: loads a weight sequence and reports the least
// cost of cutting it into num_groups contiguous groups. Depends on wlp_pkg,
// wlp_ctrl and wlp_dp.
//
// Weights are taken one item per cycle and stored as prefix sums; the item
// with tlast closes the sequence. The search then runs with the input stalled:
// for every layer a clearing sweep over the n+1 entries of the layer's cost
// memory, then one pass of the divide-and-conquer stack in which the split
// points of each span are tried one after another, since they all share one
// memory read port and one multiplier. An infeasible sequence (fewer items
// than groups, or zero groups) skips the search and goes to the result.
// The result waits in an output register, so the next sequence can load while
// it is pending. num_groups must be written by the user only between
// sequences; the block itself does not enforce it.
module weighted_line_partition_dp_unit #(
	parameter int MAX_ITEMS  = 4096,
	parameter int MAX_GROUPS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wlp_pkg::NG_W-1:0]     cfg_wdata,    // num_groups
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [wlp_pkg::WEIGHT_W-1:0] s_tdata,      // weight
	input  logic                         s_tlast,      // last_item
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [wlp_pkg::COST_OUT_W-1:0] m_tdata,    // min_cost
	output logic                         m_tuser       // feasible
);

	wlp_pkg::cmd_t cmd;
	wlp_pkg::sts_t sts;
	logic [wlp_pkg::NG_W-1:0] num_groups_q;

	// Group count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_groups_q <= wlp_pkg::NG_W'(1);
		end else if (cfg_we) begin
			num_groups_q <= cfg_wdata;
		end
	end

	wlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wlp_dp #(
		.MAX_ITEMS  (MAX_ITEMS),
		.MAX_GROUPS (MAX_GROUPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_weight    (s_tdata),
		.in_last      (s_tlast),
		.num_groups   (num_groups_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_cost     (m_tdata),
		.out_feasible (m_tuser)
	);

endmodule

>>> verif/weighted_line_partition_dp_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the weighted line partition unit: watches the weight, result and register
// channels, predicts each least-cost result and compares it. Depends on wlp_pkg.
module weighted_line_partition_dp_unit_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [wlp_pkg::NG_W-1:0]                cfg_wdata,
	input  logic                                    s_tvalid,
	input  logic                                    s_tready,
	input  logic [wlp_pkg::WEIGHT_W-1:0]            s_tdata,
	input  logic                                    s_tlast,
	input  logic                                    m_tvalid,
	input  logic                                    m_tready,
	input  logic [wlp_pkg::COST_OUT_W-1:0]          m_tdata,
	input  logic                                    m_tuser,
	output int                                      results_pending,
	output int                                      fail_count
);

	localparam int SEQ_MAX = 4096;
	localparam int GROUPS_MAX = 10;
	localparam int SPAN_DEPTH = 48;
	localparam longint unsigned COST_INF = (64'd1 << 41) - 1;

	typedef struct {
		logic [wlp_pkg::COST_OUT_W-1:0] min_cost;
		logic                           feasible;
	} partition_result_t;

	partition_result_t        expected_results[$];
	logic [wlp_pkg::NG_W-1:0] group_setting;
	int                       seq_len;
	longint unsigned          weight_sum[0:SEQ_MAX];
	longint unsigned          pos_weight_sum[0:SEQ_MAX];
	longint unsigned          cost_prev[0:SEQ_MAX];
	longint unsigned          cost_cur[0:SEQ_MAX];
	int                       span_lo[SPAN_DEPTH], span_hi[SPAN_DEPTH];
	int                       span_klo[SPAN_DEPTH], span_khi[SPAN_DEPTH];
	int                       span_top;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Cost of one group spanning positions a..b.
	function automatic longint unsigned group_cost(input int a, input int b);
		longint unsigned wp, ws;
		wp = pos_weight_sum[b] - pos_weight_sum[a - 1];
		ws = weight_sum[b] - weight_sum[a - 1];
		return wp - longint'(a) * ws;
	endfunction

	function automatic void push_span(input int lo, input int hi, input int klo, input int khi);
		if (lo > hi || span_top >= SPAN_DEPTH)
			return;
		span_lo[span_top] = lo;
		span_hi[span_top] = hi;
		span_klo[span_top] = klo;
		span_khi[span_top] = khi;
		span_top++;
	endfunction

	// One layer of the partition search, divide and conquer over split points.
	function automatic void solve_layer(input int layer, input int n);
		int lo, hi, klo, khi, mid, kend, best;
		longint unsigned cand;
		for (int i = 0; i <= n; i++)
			cost_cur[i] = COST_INF;
		span_top = 0;
		push_span(layer, n, layer, n);
		while (span_top > 0) begin
			span_top--;
			lo = span_lo[span_top];
			hi = span_hi[span_top];
			klo = span_klo[span_top];
			khi = span_khi[span_top];
			mid = (lo + hi) >> 1;
			kend = khi < mid ? khi : mid;
			best = 0;
			for (int k = klo; k <= kend; k++) begin
				cand = group_cost(k, mid) + cost_prev[k - 1];
				if (cost_cur[mid] > cand) begin
					cost_cur[mid] = cand;
					best = k;
				end
			end
			if (best != 0) begin
				push_span(mid + 1, hi, best, khi);
				if (mid > lo)
					push_span(lo, mid - 1, klo, best);
			end
		end
	endfunction

	function automatic partition_result_t predict_partition(input int n);
		partition_result_t r;
		int groups;
		groups = group_setting > GROUPS_MAX ? GROUPS_MAX : int'(group_setting);
		r.min_cost = '0;
		r.feasible = 1'b0;
		if (groups == 0 || n < groups)
			return r;
		cost_prev[0] = 0;
		for (int i = 1; i <= n; i++)
			cost_prev[i] = COST_INF;
		for (int layer = 1; layer <= groups; layer++) begin
			solve_layer(layer, n);
			for (int i = 0; i <= n; i++)
				cost_prev[i] = cost_cur[i];
		end
		r.min_cost = cost_prev[n][wlp_pkg::COST_OUT_W-1:0];
		r.feasible = 1'b1;
		return r;
	endfunction

	// Track the register, the incoming weights and the outgoing results.
	always @(posedge clk or negedge arst_n) begin
		partition_result_t want;
		if (!arst_n) begin
			group_setting = wlp_pkg::NG_W'(1);
			seq_len = 0;
			weight_sum[0] = 0;
			pos_weight_sum[0] = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				group_setting = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (seq_len < SEQ_MAX) begin
					seq_len++;
					weight_sum[seq_len] = weight_sum[seq_len - 1] + s_tdata;
					pos_weight_sum[seq_len] = pos_weight_sum[seq_len - 1]
						+ longint'(s_tdata) * seq_len;
				end
				if (s_tlast) begin
					expected_results = {expected_results, predict_partition(seq_len)};
					seq_len = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result cost", 64'(m_tdata), 0);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata !== want.min_cost)
						report_mismatch("min_cost", 64'(m_tdata), 64'(want.min_cost));
					if (m_tuser !== want.feasible)
						report_mismatch("feasible", 64'(m_tuser), 64'(want.feasible));
				end
			end
		end
		results_pending = expected_results.size();
	end

endmodule

>>> verif/weighted_line_partition_dp_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the weighted line partition unit: makes weight sequences, register
// writes and output stalls. Depends on wlp_pkg, the unit and its checker.
module weighted_line_partition_dp_unit_tb;

	localparam longint CYCLE_LIMIT = 20000000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [wlp_pkg::NG_W-1:0]       cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [wlp_pkg::WEIGHT_W-1:0]   s_tdata = '0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [wlp_pkg::COST_OUT_W-1:0] m_tdata;
	logic                           m_tuser;
	int                             results_pending;
	int                             fail_count;
	int                             burst_left = 0;
	bit                             hold_request = 0;
	longint                         cycle_count = 0;

	weighted_line_partition_dp_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	weighted_line_partition_dp_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.results_pending(results_pending), .fail_count(fail_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Overall cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result receiver: random stall patterns, with a long hold on request.
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 2);
			for (int i = 0; i < 64; i++) begin
				if (hold_request) begin
					hold_request = 0;
					m_tready <= 1'b0;
					repeat (3000) @(posedge clk);
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offer one weight item; bursts of random length with random gaps between them.
	task automatic send_weight(input logic [wlp_pkg::WEIGHT_W-1:0] w, input logic closing);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tlast <= closing;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		burst_left--;
	endtask

	// Weight styles: 0 full range, 1 small, 2 alternating extremes, 3 all zero.
	task automatic send_sequence(input int n, input int style);
		logic [wlp_pkg::WEIGHT_W-1:0] w;
		for (int i = 0; i < n; i++) begin
			case (style)
				0: w = wlp_pkg::WEIGHT_W'($urandom_range(0, 65535));
				1: w = wlp_pkg::WEIGHT_W'($urandom_range(0, 15));
				2: w = (i % 2) ? 16'hFFFF : 16'h0000;
				default: w = '0;
			endcase
			send_weight(w, i == n - 1);
		end
	endtask

	// Register write once the unit has drained every pending result.
	task automatic set_groups(input logic [wlp_pkg::NG_W-1:0] value);
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (results_pending == 0);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int n, style;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single item, zero groups, too few items, extremes, clamped setting, ties.
		send_weight(16'hFFFF, 1'b1);
		set_groups(4'd0);
		send_sequence(3, 0);
		set_groups(4'd10);
		send_sequence(5, 2);
		send_sequence(10, 2);
		set_groups(4'd15);
		send_sequence(12, 0);
		set_groups(4'd2);
		send_sequence(4, 3);

		// Long output hold while sequences keep arriving, so the input backs up.
		set_groups(4'd3);
		hold_request = 1;
		for (int s = 0; s < 4; s++)
			send_sequence(int'($urandom_range(3, 12)), 0);

		// Random phases with random settings, extremes forced in the first two.
		for (int phase = 0; phase < 10; phase++) begin
			set_groups(phase == 0 ? 4'd1 : phase == 1 ? 4'd10 : 4'($urandom_range(0, 15)));
			for (int s = 0; s < 6; s++) begin
				n = ($urandom_range(0, 15) == 0) ? int'($urandom_range(40, 150))
					: int'($urandom_range(1, 20));
				style = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
				send_sequence(n, style);
			end
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (results_pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
